// ===== design/dmoa_pkg.sv =====
// shared types, constants and the month length table for the minute offset adder
// used by the controller, the datapath and the top level, no dependencies
`timescale 1ns / 1ps

package dmoa_pkg;

  // field widths
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned OffsetW  = 21;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // arithmetic widths
  localparam int unsigned HrMinW   = 11;  // hour*60+minute, up to 1923
  localparam int unsigned TotalW   = 23;  // signed sum of minutes
  localparam int unsigned MagW     = 21;  // magnitude of the sum
  localparam int unsigned QuoW     = 10;  // whole days, up to 729

  localparam int unsigned MinPerDay     = 1440;
  localparam int unsigned MinPerHour    = 60;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned LastMonthCode = 15;

  // reciprocal multipliers: exact floor quotient over the whole operand range
  localparam int unsigned DayRecip = 1491309;  // ceil(2^31 / 1440)
  localparam int unsigned DayShift = 31;
  localparam int unsigned HrRecip  = 1093;     // ceil(2^16 / 60)
  localparam int unsigned HrShift  = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_DAY,
    S_REM_DAY,
    S_FIX,
    S_DIV_HR,
    S_REM_HR,
    S_WALK,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture an input transfer
    logic day_div;    // whole days by reciprocal multiply
    logic day_rem;    // minutes left over within the day
    logic fix;        // floor correction, start the date walk
    logic hr_div;     // hour by reciprocal multiply
    logic hr_rem;     // minute left over within the hour
    logic walk_step;  // one month step of the date walk
    logic out_load;   // capture the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic days_zero;
  } status_t;

  typedef struct packed {
    logic [OffsetW-1:0] minute_offset;
    logic [MinuteW-1:0] in_minute;
    logic [HourW-1:0]   in_hour;
    logic [DayW-1:0]    in_day;
    logic [MonthW-1:0]  in_month;
  } in_item_t;

  typedef struct packed {
    logic [MinuteW-1:0] out_minute;
    logic [HourW-1:0]   out_hour;
    logic [DayW-1:0]    out_day;
    logic [MonthW-1:0]  out_month;
  } out_item_t;

  // non-leap year, out-of-range months count as 31 days
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                       len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/dmoa_ctrl.sv =====
// controller for the minute offset adder: sequencing fsm and output valid
// depends on dmoa_pkg
`timescale 1ns / 1ps

module dmoa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dmoa_pkg::status_t status_i,
  output dmoa_pkg::cmd_t    cmd_o
);

  dmoa_pkg::state_e           state_q, state_d;
  logic                       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmoa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      dmoa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dmoa_pkg::S_DIV_DAY;
        end
      end
      dmoa_pkg::S_DIV_DAY: begin
        cmd_o.day_div = 1'b1;
        state_d       = dmoa_pkg::S_REM_DAY;
      end
      dmoa_pkg::S_REM_DAY: begin
        cmd_o.day_rem = 1'b1;
        state_d       = dmoa_pkg::S_FIX;
      end
      dmoa_pkg::S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = dmoa_pkg::S_DIV_HR;
      end
      dmoa_pkg::S_DIV_HR: begin
        // hour split and month walk run side by side
        cmd_o.hr_div    = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d         = dmoa_pkg::S_REM_HR;
      end
      dmoa_pkg::S_REM_HR: begin
        cmd_o.hr_rem    = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d         = dmoa_pkg::S_WALK;
      end
      dmoa_pkg::S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.days_zero) begin
          state_d = dmoa_pkg::S_DONE;
        end
      end
      dmoa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = dmoa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dmoa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/dmoa_dp.sv =====
// datapath for the minute offset adder: minute sum, reciprocal dividers,
// month walk and output register; depends on dmoa_pkg
`timescale 1ns / 1ps

module dmoa_dp (
  input  logic                 clk_i,
  input  dmoa_pkg::in_item_t   in_item_i,
  input  dmoa_pkg::cmd_t       cmd_i,
  output dmoa_pkg::status_t    status_o,
  output dmoa_pkg::out_item_t  out_item_o
);

  localparam int unsigned MW = dmoa_pkg::MonthW;
  localparam int unsigned DW = dmoa_pkg::DayW;
  localparam int unsigned QW = dmoa_pkg::QuoW;
  localparam int unsigned AW = dmoa_pkg::MagW;
  localparam int unsigned RW = dmoa_pkg::HrMinW;  // minutes within a day
  localparam int unsigned SW = 12;  // signed width for the walk compare

  // division
  logic [AW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic          neg_q, neg_d;
  // walk
  logic [MW-1:0] month_q, month_d;
  logic [DW-1:0] day_q, day_d;
  logic [QW-1:0] days_q, days_d;
  logic          bwd_q, bwd_d;
  logic          orig_ok_q, orig_ok_d;
  dmoa_pkg::out_item_t out_q, out_d;

  // load path
  logic [dmoa_pkg::HrMinW-1:0] hr_min;
  logic [dmoa_pkg::TotalW-1:0] total;
  logic [dmoa_pkg::TotalW-1:0] total_abs;

  // reciprocal products
  logic [2*AW-1:0] day_prod;
  logic [2*RW-1:0] hr_prod;

  // walk step
  logic [DW-1:0] len, prev_len;
  logic [MW-1:0] next_month, prev_month;
  logic [SW-1:0] remain, days_ext, fwd_left;

  always_comb begin
    hr_min = dmoa_pkg::HrMinW'(in_item_i.in_hour) * dmoa_pkg::HrMinW'(dmoa_pkg::MinPerHour)
           + dmoa_pkg::HrMinW'(in_item_i.in_minute);
    total  = {{(dmoa_pkg::TotalW - dmoa_pkg::OffsetW){in_item_i.minute_offset[dmoa_pkg::OffsetW-1]}},
              in_item_i.minute_offset}
           + {{(dmoa_pkg::TotalW - dmoa_pkg::HrMinW){1'b0}}, hr_min};
    total_abs = total[dmoa_pkg::TotalW-1] ? (~total + 1'b1) : total;

    day_prod = (2*AW)'(rem_q) * (2*AW)'(dmoa_pkg::DayRecip);
    hr_prod  = (2*RW)'(rem_q[RW-1:0]) * (2*RW)'(dmoa_pkg::HrRecip);

    len        = dmoa_pkg::month_len(month_q);
    // wrap after code 15, and after december when the start month code was 12 or less
    if (month_q == MW'(dmoa_pkg::LastMonthCode) ||
        (month_q == MW'(dmoa_pkg::MonthsPerYear) && orig_ok_q)) begin
      next_month = MW'(1);
    end else begin
      next_month = month_q + 1'b1;
    end
    if (month_q <= MW'(1)) begin
      prev_month = MW'(dmoa_pkg::MonthsPerYear);
    end else begin
      prev_month = month_q - 1'b1;
    end
    prev_len = dmoa_pkg::month_len(prev_month);

    remain   = SW'(len) - SW'(day_q);
    days_ext = SW'(days_q);
    fwd_left = days_ext - remain - SW'(1);
  end

  always_comb begin
    rem_d     = rem_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    month_d   = month_q;
    day_d     = day_q;
    days_d    = days_q;
    bwd_d     = bwd_q;
    orig_ok_d = orig_ok_q;
    out_d     = out_q;

    if (cmd_i.load) begin
      rem_d     = total_abs[AW-1:0];
      quo_d     = '0;
      neg_d     = total[dmoa_pkg::TotalW-1];
      month_d   = in_item_i.in_month;
      day_d     = in_item_i.in_day;
      days_d    = '0;
      orig_ok_d = (in_item_i.in_month <= MW'(dmoa_pkg::MonthsPerYear));
    end

    if (cmd_i.day_div) begin
      quo_d = day_prod[dmoa_pkg::DayShift +: QW];
    end

    if (cmd_i.day_rem) begin
      rem_d = rem_q - AW'(quo_q) * AW'(dmoa_pkg::MinPerDay);
    end

    if (cmd_i.fix) begin
      // floor division: a negative sum with a remainder borrows one more day
      if (neg_q && rem_q != '0) begin
        days_d = quo_q + 1'b1;
        rem_d  = AW'(dmoa_pkg::MinPerDay) - rem_q;
      end else begin
        days_d = quo_q;
      end
      bwd_d = neg_q;
    end

    if (cmd_i.hr_div) begin
      quo_d = QW'(hr_prod[dmoa_pkg::HrShift +: dmoa_pkg::HourW]);
    end

    if (cmd_i.hr_rem) begin
      rem_d = rem_q - AW'(quo_q) * AW'(dmoa_pkg::MinPerHour);
    end

    if (cmd_i.walk_step && days_q != '0) begin
      if (!bwd_q) begin
        if ($signed(days_ext) <= $signed(remain)) begin
          day_d  = day_q + DW'(days_q);
          days_d = '0;
        end else begin
          days_d  = fwd_left[QW-1:0];
          day_d   = DW'(1);
          month_d = next_month;
        end
      end else begin
        if (days_q < QW'(day_q)) begin
          day_d  = day_q - DW'(days_q);
          days_d = '0;
        end else begin
          days_d  = days_q - QW'(day_q);
          month_d = prev_month;
          day_d   = prev_len;
        end
      end
    end

    if (cmd_i.out_load) begin
      out_d.out_month  = month_q;
      out_d.out_day    = day_q;
      out_d.out_hour   = quo_q[dmoa_pkg::HourW-1:0];
      out_d.out_minute = rem_q[dmoa_pkg::MinuteW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    month_q   <= month_d;
    day_q     <= day_d;
    days_q    <= days_d;
    bwd_q     <= bwd_d;
    orig_ok_q <= orig_ok_d;
    out_q     <= out_d;
  end

  assign status_o.days_zero = (days_q == '0);
  assign out_item_o         = out_q;

endmodule

// ===== design/datetime_minute_offset_adder_core.sv =====
// top level of the minute offset adder: stream ports, controller and datapath
// depends on dmoa_pkg, dmoa_ctrl and dmoa_dp
`timescale 1ns / 1ps

// Adds a signed minute offset to a month/day/hour/minute timestamp in a fixed
// non-leap calendar; December rolls over to January and no year is kept. One
// item is in flight at a time. After the input transfer the block forms the
// whole-day quotient (reciprocal multiply), then the minutes left within the
// day, then the floor correction; then the hour quotient and the minute
// remainder are formed in turn while the date walks one month per cycle, the
// controller sees the walk end and the output register is loaded. The block
// returns to idle before the next input transfer. The month walk dominates for
// large offsets. The output register holds a finished result while the next
// item is already being taken in; a new result waits only if the old one is
// still untaken.

module datetime_minute_offset_adder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: in_month[3:0], in_day[8:4], in_hour[13:9], in_minute[19:14],
  // minute_offset[40:20], zeros[47:41]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  // master side: out_month[3:0], out_day[8:4], out_hour[13:9],
  // out_minute[19:14], zeros[23:20]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o
);

  dmoa_pkg::cmd_t      cmd;
  dmoa_pkg::status_t   status;
  dmoa_pkg::in_item_t  in_item;
  dmoa_pkg::out_item_t out_item;

  // unpack the fields of the incoming transfer
  assign in_item = s_axis_tdata_i[$bits(dmoa_pkg::in_item_t)-1:0];

  // sequencing: idle, day split, correction, hour split with month walk, handoff
  dmoa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and the output register
  dmoa_dp u_dp (
    .clk_i      (clk_i),
    .in_item_i  (in_item),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item)
  );

  // pad the result up to whole bytes
  assign m_axis_tdata_o = {{(dmoa_pkg::OutDataW - $bits(dmoa_pkg::out_item_t)){1'b0}}, out_item};

endmodule

// ===== design/dmoa_checker.sv =====
// port-level checks for the minute offset adder, bound to the top level
// depends on datetime_minute_offset_adder_core
`timescale 1ns / 1ps

module dmoa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in progress");

  // a new result only appears out of a busy phase
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without work");

  // time of day always folded into range
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[13:9] < 5'd24)
    else $error("hour out of range");

  a_minute_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[19:14] < 6'd60)
    else $error("minute out of range");

endmodule

bind datetime_minute_offset_adder_core dmoa_checker u_dmoa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
